[sv/dwconv_pkg.sv]
package dwconv_pkg;

   // Filter geometry
   localparam int TAPS       = 4;
   localparam int HIST_DEPTH = TAPS - 1;

   // Result queue
   localparam int FIFO_DEPTH = 8;
   localparam int FIFO_AW    = 3;
   localparam int CNT_W      = 4;

   // Channel count after reset
   localparam logic [10:0] CHANNEL_COUNT_RESET = 11'd1024;

   // Q8.26 -> Q4.12 rounding and Q4.12 limits
   localparam int FRAC_SHIFT = 14;
   localparam logic signed [34:0] ROUND_HALF = 35'sd8192;
   localparam logic signed [20:0] Q_MAX_WIDE = 21'sd32767;
   localparam logic signed [20:0] Q_MIN_WIDE = -21'sd32768;
   localparam logic signed [15:0] Q_MAX = 16'sh7fff;
   localparam logic signed [15:0] Q_MIN = 16'sh8000;

   typedef enum logic [1:0] {
      OP_SAMPLE     = 2'd0,
      OP_WRITE_WGT  = 2'd1,
      OP_WRITE_HIST = 2'd2,
      OP_READ_HIST  = 2'd3
   } op_type;

   typedef struct packed {
      op_type             op;
      logic [9:0]         channel_index;
      logic [1:0]         tap_index;
      logic signed [15:0] data_value;
   } req_type;

   typedef struct packed {
      logic signed [15:0] out_value;
      logic               saturated;
      logic               bad_index;
   } rsp_type;

   // Whole-row store writes issued by the read-modify-write stage, also kept for forwarding
   typedef struct packed {
      logic                         hist_we;
      logic [HIST_DEPTH-1:0][15:0]  hist_wd;
      logic                         wgt_we;
      logic [TAPS-1:0][15:0]        wgt_wd;
   } wr_type;

endpackage

[sv/dwconv_ram.sv]
module dwconv_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // One write port, one registered read port (old data on a same-address write)
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[sv/causal_depthwise_conv1d_k4.sv]
// Per-channel causal 4-tap FIR with weight loading and load and save of history.
// Input items arrive on req_valid/req_ready/req_data: a sample, a weight
// write, a history write or a history read for one channel. Samples, history
// reads and items with a bad channel or slot give one item on
// rsp_valid/rsp_ready/rsp_data; valid weight and history writes give none.
// csr_we/csr_wdata set the number of channels in use.
// Throughput: one item per cycle for any mix of channels while req_ready is
// high; the forwarding path after the history and weight memories lets the
// same channel follow itself in the next cycle.
// Path: an accepted item passes the registered memory read, the tap products
// and the pairwise sums, then the final sum enters the result queue.
// Stalls: results wait in an 8-entry queue; req_ready drops while the items in
// flight plus those queued reach 8, so nothing is ever dropped.
// Reset: synchronous. After reset the history memory is cleared one
// channel per cycle, all CHANNELS rows, with req_ready low; the channel count
// returns to 1024. Weights are unknown until written.
module causal_depthwise_conv1d_k4 #(
   parameter int CHANNELS = 1024
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  dwconv_pkg::req_type req_data,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output dwconv_pkg::rsp_type rsp_data,
   input  logic                csr_we,
   input  logic [10:0]         csr_wdata
);

   localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int HD   = dwconv_pkg::HIST_DEPTH;
   localparam int NT   = dwconv_pkg::TAPS;

   // Channel count register
   logic [10:0] channel_count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         channel_count_ff <= dwconv_pkg::CHANNEL_COUNT_RESET;
      end else if (csr_we) begin
         channel_count_ff <= csr_wdata;
      end
   end

   // History clearing pass after reset
   logic            clr_active_ff;
   logic [CH_W-1:0] clr_addr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_active_ff <= 1'b1;
         clr_addr_ff   <= '0;
      end else if (clr_active_ff) begin
         if (clr_addr_ff == CH_W'(CHANNELS - 1)) begin
            clr_active_ff <= 1'b0;
         end
         clr_addr_ff <= clr_addr_ff + 1'b1;
      end
   end

   // Credit check: items in flight plus queued must fit the queue
   logic                              p1_valid_ff, p2_valid_ff, p3_valid_ff;
   logic [dwconv_pkg::CNT_W-1:0]      fifo_count_ff;
   logic [dwconv_pkg::CNT_W-1:0]      occupancy;
   logic                              accept;

   assign occupancy = dwconv_pkg::CNT_W'(p1_valid_ff) + dwconv_pkg::CNT_W'(p2_valid_ff)
                    + dwconv_pkg::CNT_W'(p3_valid_ff) + fifo_count_ff;
   assign req_ready = !clr_active_ff
                   && (occupancy < dwconv_pkg::CNT_W'(dwconv_pkg::FIFO_DEPTH));
   assign accept    = req_valid && req_ready;

   // Index check at acceptance
   logic            ch_ok, slot_bad, req_bad;
   logic [CH_W-1:0] req_ch;

   assign req_ch   = CH_W'(req_data.channel_index);
   assign ch_ok    = (32'(req_data.channel_index) < CHANNELS)
                  && ({1'b0, req_data.channel_index} < channel_count_ff);
   assign slot_bad = ((req_data.op == dwconv_pkg::OP_WRITE_HIST)
                  || (req_data.op == dwconv_pkg::OP_READ_HIST))
                  && (req_data.tap_index >= 2'(HD));
   assign req_bad  = !ch_ok || slot_bad;

   // Stage 1: item alongside the memory read data
   dwconv_pkg::op_type p1_op_ff;
   logic [CH_W-1:0]    p1_ch_ff;
   logic [1:0]         p1_tap_ff;
   logic [15:0]        p1_data_ff;
   logic               p1_bad_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_valid_ff <= 1'b0;
      end else begin
         p1_valid_ff <= accept;
      end
      p1_op_ff   <= req_data.op;
      p1_ch_ff   <= req_ch;
      p1_tap_ff  <= req_data.tap_index;
      p1_data_ff <= req_data.data_value;
      p1_bad_ff  <= req_bad;
   end

   // History and weight memories, one row per channel holding all slots or taps
   logic [HD*16-1:0]   hist_rd;
   logic [NT*16-1:0]   wgt_rd;
   logic               hist_we;
   logic [CH_W-1:0]    hist_wa;
   logic [HD*16-1:0]   hist_wd;
   dwconv_pkg::wr_type wr;

   assign hist_we = clr_active_ff || wr.hist_we;
   assign hist_wa = clr_active_ff ? clr_addr_ff : p1_ch_ff;
   assign hist_wd = clr_active_ff ? '0 : wr.hist_wd;

   dwconv_ram #(
      .WIDTH (HD * 16),
      .DEPTH (CHANNELS)
   ) u_hist_ram (
      .clock   (clock),
      .wr_en   (hist_we),
      .wr_addr (hist_wa),
      .wr_data (hist_wd),
      .rd_addr (req_ch),
      .rd_data (hist_rd)
   );

   dwconv_ram #(
      .WIDTH (NT * 16),
      .DEPTH (CHANNELS)
   ) u_wgt_ram (
      .clock   (clock),
      .wr_en   (wr.wgt_we),
      .wr_addr (p1_ch_ff),
      .wr_data (wr.wgt_wd),
      .rd_addr (req_ch),
      .rd_data (wgt_rd)
   );

   // Forwarding of the write made at the edge the stage-1 read was taken
   logic               fwd_valid_ff;
   logic [CH_W-1:0]    fwd_ch_ff;
   dwconv_pkg::wr_type fwd_ff;
   logic               fwd_hit;
   logic [15:0]        eff_h [HD];
   logic [15:0]        eff_w [NT];

   assign fwd_hit = fwd_valid_ff && (fwd_ch_ff == p1_ch_ff);

   always_comb begin
      for (int i = 0; i < HD; i++) begin
         eff_h[i] = (fwd_hit && fwd_ff.hist_we) ? fwd_ff.hist_wd[i] : hist_rd[i*16 +: 16];
      end
      for (int i = 0; i < NT; i++) begin
         eff_w[i] = (fwd_hit && fwd_ff.wgt_we) ? fwd_ff.wgt_wd[i] : wgt_rd[i*16 +: 16];
      end
   end

   // Write-back of the whole row: shift history on a sample, or replace one word
   always_comb begin
      wr = '0;
      if (p1_valid_ff && !p1_bad_ff) begin
         unique case (p1_op_ff)
            dwconv_pkg::OP_SAMPLE: begin
               wr.hist_we    = 1'b1;
               wr.hist_wd[0] = eff_h[1];
               wr.hist_wd[1] = eff_h[2];
               wr.hist_wd[2] = p1_data_ff;
            end
            dwconv_pkg::OP_WRITE_WGT: begin
               wr.wgt_we = 1'b1;
               for (int i = 0; i < NT; i++) begin
                  wr.wgt_wd[i] = (p1_tap_ff == 2'(i)) ? p1_data_ff : eff_w[i];
               end
            end
            dwconv_pkg::OP_WRITE_HIST: begin
               wr.hist_we = 1'b1;
               for (int i = 0; i < HD; i++) begin
                  wr.hist_wd[i] = (p1_tap_ff == 2'(i)) ? p1_data_ff : eff_h[i];
               end
            end
            dwconv_pkg::OP_READ_HIST: begin
               wr = '0;
            end
            default: begin
               wr = '0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_valid_ff <= 1'b0;
      end else begin
         fwd_valid_ff <= p1_valid_ff && !p1_bad_ff;
      end
      fwd_ch_ff <= p1_ch_ff;
      fwd_ff    <= wr;
   end

   // History word for a read
   logic [15:0] read_word;

   always_comb begin
      unique case (p1_tap_ff)
         2'd0:    read_word = eff_h[0];
         2'd1:    read_word = eff_h[1];
         2'd2:    read_word = eff_h[2];
         default: read_word = 16'd0;
      endcase
   end

   // Stage 2: tap products
   logic                      p1_has_rsp;
   logic signed [31:0]        prod_in [NT];
   logic signed [31:0]        p2_prod_ff [NT];
   dwconv_pkg::op_type        p2_op_ff;
   logic                      p2_bad_ff;
   logic [15:0]               p2_word_ff;

   assign p1_has_rsp = p1_bad_ff || (p1_op_ff == dwconv_pkg::OP_SAMPLE)
                    || (p1_op_ff == dwconv_pkg::OP_READ_HIST);

   always_comb begin
      for (int i = 0; i < HD; i++) begin
         prod_in[i] = $signed(eff_w[i]) * $signed(eff_h[i]);
      end
      prod_in[NT-1] = $signed(eff_w[NT-1]) * $signed(p1_data_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p2_valid_ff <= 1'b0;
      end else begin
         p2_valid_ff <= p1_valid_ff && p1_has_rsp;
      end
      p2_prod_ff <= prod_in;
      p2_op_ff   <= p1_op_ff;
      p2_bad_ff  <= p1_bad_ff;
      p2_word_ff <= read_word;
   end

   // Stage 3: pairwise sums
   logic signed [32:0] p3_s01_ff, p3_s23_ff;
   dwconv_pkg::op_type p3_op_ff;
   logic               p3_bad_ff;
   logic [15:0]        p3_word_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         p3_valid_ff <= 1'b0;
      end else begin
         p3_valid_ff <= p2_valid_ff;
      end
      p3_s01_ff  <= 33'(p2_prod_ff[0]) + 33'(p2_prod_ff[1]);
      p3_s23_ff  <= 33'(p2_prod_ff[2]) + 33'(p2_prod_ff[3]);
      p3_op_ff   <= p2_op_ff;
      p3_bad_ff  <= p2_bad_ff;
      p3_word_ff <= p2_word_ff;
   end

   // Final sum, round half up to Q4.12, saturate, build the result item
   logic signed [33:0]  acc;
   logic signed [34:0]  biased;
   logic signed [20:0]  rounded;
   dwconv_pkg::rsp_type result;

   assign acc     = 34'(p3_s01_ff) + 34'(p3_s23_ff);
   assign biased  = 35'(acc) + dwconv_pkg::ROUND_HALF;
   assign rounded = 21'(biased >>> dwconv_pkg::FRAC_SHIFT);

   always_comb begin
      result = '0;
      if (p3_bad_ff) begin
         result.bad_index = 1'b1;
      end else if (p3_op_ff == dwconv_pkg::OP_READ_HIST) begin
         result.out_value = p3_word_ff;
      end else if (rounded > dwconv_pkg::Q_MAX_WIDE) begin
         result.out_value = dwconv_pkg::Q_MAX;
         result.saturated = 1'b1;
      end else if (rounded < dwconv_pkg::Q_MIN_WIDE) begin
         result.out_value = dwconv_pkg::Q_MIN;
         result.saturated = 1'b1;
      end else begin
         result.out_value = rounded[15:0];
      end
   end

   // Result queue
   dwconv_pkg::rsp_type             fifo_mem_ff [dwconv_pkg::FIFO_DEPTH];
   logic [dwconv_pkg::FIFO_AW-1:0]  wr_ptr_ff, rd_ptr_ff;
   logic                            push, pop;

   assign push      = p3_valid_ff;
   assign rsp_valid = (fifo_count_ff != '0);
   assign pop       = rsp_valid && rsp_ready;
   assign rsp_data  = fifo_mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff     <= '0;
         rd_ptr_ff     <= '0;
         fifo_count_ff <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         fifo_count_ff <= fifo_count_ff + dwconv_pkg::CNT_W'(push)
                        - dwconv_pkg::CNT_W'(pop);
      end
      if (push) begin
         fifo_mem_ff[wr_ptr_ff] <= result;
      end
   end

`ifndef SYNTHESIS
   // Credit scheme keeps in-flight plus queued items within the queue
   assert property (@(posedge clock) disable iff (reset)
      occupancy <= dwconv_pkg::CNT_W'(dwconv_pkg::FIFO_DEPTH))
      else $error("result queue credit exceeded");

   // No push into a full queue unless an item leaves in the same cycle
   assert property (@(posedge clock) disable iff (reset)
      (push && fifo_count_ff == dwconv_pkg::CNT_W'(dwconv_pkg::FIFO_DEPTH)) |-> pop)
      else $error("result queue overflow");

   // No item is taken while the history clear is running
   assert property (@(posedge clock) disable iff (reset)
      clr_active_ff |-> !req_ready)
      else $error("item accepted during history clear");

   // A flagged item carries a zero value and no saturation
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.bad_index) |-> (rsp_data.out_value == '0 && !rsp_data.saturated))
      else $error("bad index result with payload");
`endif

endmodule

[test/tb_causal_depthwise_conv1d_k4.sv]
module tb_causal_depthwise_conv1d_k4;
   import dwconv_pkg::*;

   localparam int N_CH         = 1024;
   localparam int WORK_SET     = 6;
   localparam int HOLD_CYCLES  = 120;
   localparam int DRAIN_CYCLES = 8;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int PHASE_ITEMS  = 220;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   req_type     req_data;
   logic        rsp_valid;
   logic        rsp_ready;
   rsp_type     rsp_data;
   logic        csr_we;
   logic [10:0] csr_wdata;

   // Shadow of the block's state
   logic signed [15:0] wgt_mem  [TAPS][N_CH];
   logic signed [15:0] hist_mem [HIST_DEPTH][N_CH];
   bit [TAPS-1:0]      wgt_loaded [N_CH];
   logic [10:0]        chan_count;

   rsp_type pending_results[$];
   rsp_type want;
   int      work_ch [WORK_SET];

   int  mismatch_count;
   int  items_sent;
   int  directed_items;
   int  results_checked;
   int  sat_results;
   int  bad_results;
   int  count_settings;
   int  cycle_count;
   bit  steady;
   bit  hold_off_req;

   causal_depthwise_conv1d_k4 #(.CHANNELS(N_CH)) dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   // Clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles, %0d results outstanding",
                  cycle_count, pending_results.size());
         $display("*** FAILED ***");
         $finish;
      end
   end

   task automatic report_mismatch(input string what);
      $display("Mismatch at cycle %0d: %s", cycle_count, what);
      mismatch_count++;
   endtask

   function automatic int active_limit();
      return (chan_count < N_CH) ? int'(chan_count) : N_CH;
   endfunction

   // Filter and store model: returns 1 when the item gives a result
   function automatic bit predict_item(input req_type r, output rsp_type res);
      int      ch;
      int      k;
      longint  acc;
      longint  rnd;
      logic signed [15:0] x;
      res = '0;
      ch = int'(r.channel_index);
      x = r.data_value;
      if (ch >= active_limit() ||
          ((r.op == OP_WRITE_HIST || r.op == OP_READ_HIST) && r.tap_index >= HIST_DEPTH)) begin
         res.bad_index = 1'b1;
         return 1'b1;
      end
      case (r.op)
         OP_WRITE_WGT: begin
            wgt_mem[r.tap_index][ch] = x;
            wgt_loaded[ch][r.tap_index] = 1'b1;
            return 1'b0;
         end
         OP_WRITE_HIST: begin
            hist_mem[r.tap_index][ch] = x;
            return 1'b0;
         end
         OP_READ_HIST: begin
            res.out_value = hist_mem[r.tap_index][ch];
            return 1'b1;
         end
         default: begin
            acc = 0;
            for (k = 0; k < HIST_DEPTH; k++)
               acc += longint'(hist_mem[k][ch]) * longint'(wgt_mem[k][ch]);
            acc += longint'(x) * longint'(wgt_mem[TAPS-1][ch]);
            // round half up, then clip to Q4.12
            rnd = (acc + longint'(ROUND_HALF)) >>> FRAC_SHIFT;
            if (rnd > 32767) begin
               res.out_value = Q_MAX;
               res.saturated = 1'b1;
            end else if (rnd < -32768) begin
               res.out_value = Q_MIN;
               res.saturated = 1'b1;
            end else begin
               res.out_value = rnd[15:0];
            end
            hist_mem[0][ch] = hist_mem[1][ch];
            hist_mem[1][ch] = hist_mem[2][ch];
            hist_mem[2][ch] = x;
            return 1'b1;
         end
      endcase
   endfunction

   function automatic req_type make_req(input op_type op, input int ch, input int tap,
                                        input logic signed [15:0] data);
      req_type r;
      r.op            = op;
      r.channel_index = ch[9:0];
      r.tap_index     = tap[1:0];
      r.data_value    = data;
      return r;
   endfunction

   // No gap most often, some short, a few long
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 45) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 50);
   endfunction

   function automatic logic signed [15:0] random_word();
      case ($urandom_range(0, 9))
         0, 1, 2, 3: return 16'($urandom);
         4, 5, 6, 7: return 16'(int'($urandom_range(0, 4095)) - 2048);
         8: begin
            case ($urandom_range(0, 3))
               0:       return Q_MAX;
               1:       return Q_MIN;
               2:       return 16'sd0;
               default: return -16'sd1;
            endcase
         end
         default: return 16'(int'($urandom_range(0, 255)) - 128);
      endcase
   endfunction

   // Random item, mostly on the working set; a sample on an active channel with missing
   // weights becomes a load of the first missing tap
   function automatic req_type random_req();
      int     ch;
      int     tap;
      int     sel;
      int     k;
      op_type op;
      if ($urandom_range(0, 9) == 0)
         ch = $urandom_range(0, N_CH - 1);
      else
         ch = work_ch[$urandom_range(0, WORK_SET - 1)];
      sel = $urandom_range(0, 99);
      if (sel < 55)      op = OP_SAMPLE;
      else if (sel < 70) op = OP_WRITE_WGT;
      else if (sel < 85) op = OP_WRITE_HIST;
      else               op = OP_READ_HIST;
      if (op == OP_WRITE_HIST || op == OP_READ_HIST)
         tap = ($urandom_range(0, 9) == 0) ? 3 : $urandom_range(0, 2);
      else
         tap = $urandom_range(0, 3);
      if (op == OP_SAMPLE && ch < active_limit() && !(&wgt_loaded[ch])) begin
         op = OP_WRITE_WGT;
         for (k = TAPS - 1; k >= 0; k--)
            if (!wgt_loaded[ch][k]) tap = k;
      end
      return make_req(op, ch, tap, random_word());
   endfunction

   // Offer one item from a falling edge; returns at a falling edge
   task automatic send_item(input req_type r);
      rsp_type res;
      int      gap;
      req_data  = r;
      req_valid = 1'b1;
      do @(posedge clock); while (!req_ready);
      if (predict_item(r, res))
         pending_results.push_back(res);
      items_sent++;
      @(negedge clock);
      gap = steady ? 0 : pick_gap();
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
   endtask

   // Let every expected result arrive, plus the pipeline depth
   task automatic settle();
      req_valid = 1'b0;
      while (pending_results.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic set_channel_count(input logic [10:0] value);
      settle();
      csr_we    = 1'b1;
      csr_wdata = value;
      @(negedge clock);
      csr_we     = 1'b0;
      chan_count = value;
      count_settings++;
   endtask

   // Result checker
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_results.size() == 0) begin
            report_mismatch($sformatf("result %0d with nothing expected", rsp_data.out_value));
         end else begin
            want = pending_results.pop_front();
            results_checked++;
            if (want.saturated) sat_results++;
            if (want.bad_index) bad_results++;
            if (rsp_data.out_value !== want.out_value)
               report_mismatch($sformatf("out_value %0d, expected %0d",
                                         rsp_data.out_value, want.out_value));
            if (rsp_data.saturated !== want.saturated)
               report_mismatch($sformatf("saturated %b, expected %b",
                                         rsp_data.saturated, want.saturated));
            if (rsp_data.bad_index !== want.bad_index)
               report_mismatch($sformatf("bad_index %b, expected %b",
                                         rsp_data.bad_index, want.bad_index));
         end
      end
   end

   // Result side: random stalls, a long hold-off on request
   initial begin : rsp_side
      int stall_left;
      int hold_left;
      stall_left = 0;
      hold_left  = 0;
      rsp_ready  = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off_req) begin
            hold_off_req = 1'b0;
            hold_left    = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            rsp_ready = 1'b0;
            hold_left--;
         end else if (stall_left > 0) begin
            rsp_ready = 1'b0;
            stall_left--;
         end else begin
            rsp_ready = 1'b1;
            if (!steady && $urandom_range(0, 99) < 25) stall_left = pick_gap();
         end
      end
   end

   // Channel 0 has only w3 = 1 LSB, so the output is x / 2^14 rounded
   task automatic test_rounding_ties();
      send_item(make_req(OP_READ_HIST, 0, 0, 16'sd0));     // cleared by reset
      send_item(make_req(OP_WRITE_WGT, 0, 0, 16'sd0));
      send_item(make_req(OP_WRITE_WGT, 0, 1, 16'sd0));
      send_item(make_req(OP_WRITE_WGT, 0, 2, 16'sd0));
      send_item(make_req(OP_WRITE_WGT, 0, 3, 16'sd1));
      send_item(make_req(OP_SAMPLE, 0, 3, 16'sd8192));     // tie rounds up, tap ignored
      send_item(make_req(OP_SAMPLE, 0, 0, -16'sd8192));    // negative tie goes to zero
      send_item(make_req(OP_SAMPLE, 0, 1, Q_MAX));
      send_item(make_req(OP_READ_HIST, 0, 1, 16'sd0));
      send_item(make_req(OP_READ_HIST, 0, 2, 16'sd0));
   endtask

   // Channel 1023: large positive then large negative sums
   task automatic test_saturation();
      send_item(make_req(OP_WRITE_WGT, 1023, 0, Q_MAX));
      send_item(make_req(OP_WRITE_WGT, 1023, 1, Q_MAX));
      send_item(make_req(OP_WRITE_WGT, 1023, 2, Q_MAX));
      send_item(make_req(OP_WRITE_WGT, 1023, 3, Q_MIN));
      send_item(make_req(OP_WRITE_HIST, 1023, 0, Q_MAX));
      send_item(make_req(OP_WRITE_HIST, 1023, 1, Q_MAX));
      send_item(make_req(OP_WRITE_HIST, 1023, 2, Q_MAX));
      send_item(make_req(OP_SAMPLE, 1023, 2, Q_MAX));
      send_item(make_req(OP_WRITE_HIST, 1023, 0, Q_MIN));
      send_item(make_req(OP_WRITE_HIST, 1023, 1, Q_MIN));
      send_item(make_req(OP_WRITE_HIST, 1023, 2, Q_MIN));
      send_item(make_req(OP_SAMPLE, 1023, 0, Q_MAX));
   endtask

   // History slot three is out of range for both write and read
   task automatic test_bad_slot();
      send_item(make_req(OP_WRITE_HIST, 0, 3, 16'sh1234));
      send_item(make_req(OP_READ_HIST, 0, 3, 16'sd0));
      send_item(make_req(OP_READ_HIST, 0, 0, 16'sd0));
   endtask

   task automatic test_channel_count();
      set_channel_count(11'd0);                            // everything flagged
      send_item(make_req(OP_SAMPLE, 0, 0, 16'sd100));
      send_item(make_req(OP_WRITE_WGT, 0, 1, 16'sd5));
      set_channel_count(11'd1);
      send_item(make_req(OP_SAMPLE, 1, 0, 16'sd100));
      send_item(make_req(OP_WRITE_WGT, 1, 0, 16'sd5));
      send_item(make_req(OP_SAMPLE, 0, 0, 16'sd16384));
      set_channel_count(11'd2047);                         // limit stays at CHANNELS
      send_item(make_req(OP_SAMPLE, 1023, 0, -16'sd1));
      set_channel_count(CHANNEL_COUNT_RESET);
   endtask

   // Receiver holds off while samples and history reads keep coming: result queue fills
   task automatic test_backpressure();
      int n;
      settle();
      steady       = 1'b1;
      hold_off_req = 1'b1;
      for (n = 0; n < 40; n++)
         send_item(make_req((n % 5 == 4) ? OP_READ_HIST : OP_SAMPLE,
                            (n % 2) ? 1023 : 0, n % 3, random_word()));
      steady = 1'b0;
      settle();
   endtask

   task automatic test_random_traffic();
      logic [10:0] phase_counts [6];
      int p;
      int n;
      int k;
      int lim;
      phase_counts[0] = 11'd1024;
      phase_counts[1] = 11'($urandom_range(2, 1023));
      phase_counts[2] = 11'd2047;
      phase_counts[3] = 11'd1;
      phase_counts[4] = 11'($urandom_range(100, 1023));
      phase_counts[5] = 11'd1024;
      for (p = 0; p < 6; p++) begin
         set_channel_count(phase_counts[p]);
         lim = active_limit();
         // small working set so the same channel often follows itself
         work_ch[0] = 0;
         work_ch[1] = lim - 1;
         for (k = 2; k < WORK_SET - 1; k++) work_ch[k] = $urandom_range(0, lim - 1);
         work_ch[WORK_SET-1] = $urandom_range(0, N_CH - 1);
         for (n = 0; n < PHASE_ITEMS; n++) begin
            if (n % 60 == 0) steady = ($urandom_range(0, 3) == 0);
            send_item(random_req());
         end
         steady = 1'b0;
      end
   endtask

   initial begin : main
      int c;
      int t;
      reset        = 1'b1;
      req_valid    = 1'b0;
      req_data     = '0;
      csr_we       = 1'b0;
      csr_wdata    = '0;
      steady       = 1'b0;
      hold_off_req = 1'b0;
      chan_count   = CHANNEL_COUNT_RESET;
      for (c = 0; c < N_CH; c++) begin
         wgt_loaded[c] = '0;
         for (t = 0; t < TAPS; t++) wgt_mem[t][c] = '0;
         for (t = 0; t < HIST_DEPTH; t++) hist_mem[t][c] = '0;
      end
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_rounding_ties();
      test_saturation();
      test_bad_slot();
      test_channel_count();
      directed_items = items_sent;
      test_backpressure();
      test_random_traffic();
      settle();

      $display("Sent %0d items (%0d directed) across %0d channel-count writes.",
               items_sent, directed_items, count_settings);
      $display("Checked %0d results: %0d clipped, %0d flagged bad index.",
               results_checked, sat_results, bad_results);
      if (mismatch_count == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule

[causal_depthwise_conv1d_k4.f]
sv/dwconv_pkg.sv
sv/dwconv_ram.sv
sv/causal_depthwise_conv1d_k4.sv
test/tb_causal_depthwise_conv1d_k4.sv
